// ===== sv/bb3_pkg.sv =====
// shared types, constants and the reciprocal table of the 3x3 rgb box blur
package bb3_pkg;

    localparam int PIX_W       = 8;
    localparam int RGB_W       = 3 * PIX_W;
    localparam int ROW_PAIR_W  = 2 * RGB_W;
    localparam int CFG_W_BITS  = 11;
    localparam int CFG_H_BITS  = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int ROW_W       = 13;
    localparam int SUM_W       = 12;
    localparam int NUM_W       = 13;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH) + 1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_W_BITS-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 12'd480;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             last_pixel;
    } t_pix_out;

    typedef struct packed {
        logic [RGB_W-1:0] px;
        logic             emit;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
        logic             last;
    } t_task;

    // ceil(2^20 / (2*count)) for the neighbour counts that can occur
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/bb3_ram.sv =====
// generic single write port ram with registered read
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/bb3_queue.sv =====
// small register fifo used between the front and back and at the output
module bb3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int CW    = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full,
    output logic [CW-1:0]    o_count
);
    import bb3_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/bb3_front.sv =====
// front end: frame position tracking, request classification and configuration
module bb3_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  bb3_pkg::t_pix_in                   i_data,
    input  logic                               i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_push,
    output logic [COL_W-1:0]                   o_col,
    output bb3_pkg::t_task                     o_task,
    input  logic                               i_full
);
    import bb3_pkg::*;

    localparam int XW = ((COL_W > CFG_W_BITS) ? COL_W : CFG_W_BITS) + 1;

    logic [CFG_W_BITS-1:0] r_width;
    logic [CFG_H_BITS-1:0] r_height;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;

    logic [CFG_W_BITS-1:0] w_eff;
    logic [CFG_H_BITS-1:0] h_eff;
    logic [XW-1:0]         w_x;
    logic [XW-1:0]         col_x;
    logic [XW-1:0]         ocol;
    logic [ROW_W-1:0]      h_x;
    logic [ROW_W-1:0]      orow;
    logic                  in_frame;
    logic                  accept;
    logic                  drop;
    logic                  col_nz;
    logic                  emit;
    logic                  wrap;
    logic                  last;

    always_comb begin
        w_eff = r_width;
        if (r_width == '0) begin
            w_eff = CFG_W_BITS'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = CFG_W_BITS'(MAX_WIDTH);
        end
    end

    assign h_eff    = (r_height == '0) ? CFG_H_BITS'(1) : r_height;
    assign w_x      = XW'(w_eff);
    assign col_x    = XW'(r_col);
    assign h_x      = ROW_W'(h_eff);
    assign in_frame = (r_row < h_x);
    assign accept   = i_valid && !o_stall;
    assign drop     = in_frame && (i_data.opcode == OP_DRAIN);
    assign col_nz   = (r_col != '0);
    assign emit     = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && col_nz);
    assign orow     = col_nz ? (r_row - ROW_W'(1)) : (r_row - ROW_W'(2));
    assign ocol     = col_nz ? (col_x - XW'(1)) : (w_x - XW'(1));
    assign wrap     = ((col_x + XW'(1)) >= w_x);
    assign last     = emit && (orow == (h_x - ROW_W'(1))) && (ocol == (w_x - XW'(1)));

    assign o_stall = i_full;
    assign o_push  = accept && !drop;
    assign o_col   = r_col;

    always_comb begin
        o_task.px       = '0;
        if (in_frame && (i_data.opcode == OP_PIXEL)) begin
            o_task.px = {i_data.red_in, i_data.green_in, i_data.blue_in};
        end
        o_task.emit     = emit;
        o_task.top_ok   = (orow != '0);
        o_task.bot_ok   = ((orow + ROW_W'(1)) < h_x);
        o_task.left_ok  = (ocol != '0);
        o_task.right_ok = ((ocol + XW'(1)) < w_x);
        o_task.last     = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_IDX_HEIGHT: r_height <= i_cfg_data[CFG_H_BITS-1:0];
                default:        r_width  <= r_width;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            if (last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (wrap) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= COL_W'(col_x + XW'(1));
            end
        end
    end

endmodule

// ===== sv/bb3_back.sv =====
// back end: line store, 3x3 window, masked sums and rounded mean
module bb3_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  logic [COL_W-1:0]                i_q_col,
    input  bb3_pkg::t_task                  i_q_task,
    output logic                            o_q_pop,
    input  logic [bb3_pkg::OUT_CNT_W-1:0]   i_out_count,
    output logic                            o_push,
    output bb3_pkg::t_pix_out               o_result
);
    import bb3_pkg::*;

    localparam int BUSY_W = OUT_CNT_W + 1;

    // stage 1: line store data returns, window shifts
    logic                  r_s1_v;
    logic [COL_W-1:0]      r_s1_col;
    t_task                 r_s1_task;
    logic                  r_s1_fwd;
    logic [ROW_PAIR_W-1:0] r_fwd_data;
    logic [ROW_PAIR_W-1:0] rd_data;
    logic [ROW_PAIR_W-1:0] old_pair;
    logic [ROW_PAIR_W-1:0] wr_data;
    logic [RGB_W-1:0]      r_win    [3][3];
    logic [RGB_W-1:0]      win_next [3][3];

    // stage 2: masked sums
    logic                  r_s2_v;
    logic                  r_s2_last;
    logic [2:0]            r_s2_row_ok;
    logic [2:0]            r_s2_col_ok;
    logic [SUM_W-1:0]      sum [3];
    logic [CNT_W-1:0]      cnt;

    // stage 3: numerator and reciprocal
    logic                  r_s3_v;
    logic                  r_s3_last;
    logic [NUM_W-1:0]      r_s3_num [3];
    logic [RECIP_W-1:0]    r_s3_recip;

    // stage 4: products
    logic                  r_s4_v;
    logic                  r_s4_last;
    logic [PROD_W-1:0]     r_s4_prod [3];

    logic [BUSY_W-1:0]     busy;

    assign busy = BUSY_W'(r_s1_v) + BUSY_W'(r_s2_v) + BUSY_W'(r_s3_v) + BUSY_W'(r_s4_v)
                + BUSY_W'(i_out_count);
    assign o_q_pop = i_q_valid && (busy < BUSY_W'(OUT_DEPTH));

    bb3_ram #(
        .WIDTH (ROW_PAIR_W),
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_col),
        .i_wdata (wr_data),
        .i_raddr (i_q_col),
        .o_rdata (rd_data)
    );

    assign old_pair = r_s1_fwd ? r_fwd_data : rd_data;
    assign wr_data  = {old_pair[RGB_W-1:0], r_s1_task.px};

    always_comb begin
        win_next = r_win;
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = r_win[r][1];
            win_next[r][1] = r_win[r][2];
        end
        win_next[0][2] = old_pair[ROW_PAIR_W-1:RGB_W];
        win_next[1][2] = old_pair[RGB_W-1:0];
        win_next[2][2] = r_s1_task.px;
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = '0;
        end
        cnt = '0;
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                if (r_s2_row_ok[dy] && r_s2_col_ok[dx]) begin
                    for (int c = 0; c < 3; c++) begin
                        sum[c] = sum[c] + SUM_W'(r_win[dy][dx][PIX_W*(2-c) +: PIX_W]);
                    end
                    cnt = cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= o_q_pop;
            r_s2_v <= r_s1_v && r_s1_task.emit;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col   <= i_q_col;
        r_s1_task  <= i_q_task;
        r_s1_fwd   <= r_s1_v && (r_s1_col == i_q_col);
        r_fwd_data <= wr_data;
        if (r_s1_v) begin
            r_win <= win_next;
        end
        r_s2_last   <= r_s1_task.last;
        r_s2_row_ok <= {r_s1_task.bot_ok, 1'b1, r_s1_task.top_ok};
        r_s2_col_ok <= {r_s1_task.right_ok, 1'b1, r_s1_task.left_ok};
        r_s3_last   <= r_s2_last;
        r_s3_recip  <= recip(cnt);
        for (int c = 0; c < 3; c++) begin
            r_s3_num[c]  <= (NUM_W'(sum[c]) << 1) + NUM_W'(cnt);
            r_s4_prod[c] <= PROD_W'(r_s3_num[c]) * PROD_W'(r_s3_recip);
        end
        r_s4_last <= r_s3_last;
    end

    assign o_push              = r_s4_v;
    assign o_result.red_out    = r_s4_prod[0][RECIP_SHIFT +: PIX_W];
    assign o_result.green_out  = r_s4_prod[1][RECIP_SHIFT +: PIX_W];
    assign o_result.blue_out   = r_s4_prod[2][RECIP_SHIFT +: PIX_W];
    assign o_result.last_pixel = r_s4_last;

endmodule

// ===== sv/box_blur_3x3_rgb.sv =====
// top level of the streaming 3x3 rgb box blur
//
// pixels enter in raster order on the input channel (i_in_valid, o_in_stall,
// i_in_data); opcode pixel carries data, opcode drain pushes the frame tail
// out once all pixels of the frame are in. each result on the output channel
// (o_out_valid, i_out_stall, o_out_data) is the rounded per-channel mean of
// the in-frame 3x3 neighbourhood; last_pixel marks the final pixel of a frame.
// results lag requests by image_width+1 requests; a drain request sent before
// the frame is complete is taken and ignored.
// one request per clock is sustained while o_in_stall is low. the line store
// read, window and mean run as a 4 stage pipeline fed from a 4 entry request
// queue and drained through an 8 entry result fifo; a request that releases a
// result reaches o_out_valid through the queue, the pipeline and the fifo.
// the configuration port writes image_width (index 0) or image_height
// (index 1) and restarts the frame; write only while the block is idle.
// reset restores 640x480 and an empty pipeline; the line store needs no clear.
// a stalled receiver holds the fifo head steady; once the fifo, pipeline and
// request queue fill, o_in_stall rises until results drain.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bb3_pkg::t_pix_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bb3_pkg::t_pix_out               o_out_data,
    input  logic                            i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bb3_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int TQ_W   = COL_W + $bits(t_task);
    localparam int TQ_CW  = $clog2(QUEUE_DEPTH) + 1;
    localparam int RES_W  = $bits(t_pix_out);

    logic              f_push;
    logic [COL_W-1:0]  f_col;
    t_task             f_task;
    logic              q_full;
    logic              q_valid;
    logic [TQ_W-1:0]   q_data;
    logic [COL_W-1:0]  q_col;
    t_task             q_task;
    logic [TQ_CW-1:0]  q_count;
    logic              b_pop;
    logic              b_push;
    t_pix_out          b_result;
    logic              o_full;
    logic [OUT_CNT_W-1:0] o_count;
    logic [RES_W-1:0]  o_data_raw;

    bb3_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_data      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (f_push),
        .o_col       (f_col),
        .o_task      (f_task),
        .i_full      (q_full)
    );

    bb3_queue #(
        .WIDTH (TQ_W),
        .DEPTH (QUEUE_DEPTH),
        .CW    (TQ_CW)
    ) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_col, f_task}),
        .i_pop   (b_pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_count (q_count)
    );

    assign {q_col, q_task} = q_data;

    bb3_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_col     (q_col),
        .i_q_task    (q_task),
        .o_q_pop     (b_pop),
        .i_out_count (o_count),
        .o_push      (b_push),
        .o_result    (b_result)
    );

    bb3_queue #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH),
        .CW    (OUT_CNT_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_result),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_data  (o_data_raw),
        .o_valid (o_out_valid),
        .o_full  (o_full),
        .o_count (o_count)
    );

    assign o_out_data = t_pix_out'(o_data_raw);

    a_task_q_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !q_full && (q_count != TQ_CW'(QUEUE_DEPTH)))
        else $error("request queue pushed while full");

    a_out_q_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_push |-> !o_full)
        else $error("result fifo pushed while full");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_push |-> $past(b_pop, 4))
        else $error("result without a request issued four cycles earlier");

endmodule
